// File: rtl/plc_pkg.sv
// Package for the polyline length and centroid block.
// Holds the word types, widths and state codes; no dependencies.
`timescale 1ns / 1ps
package plc_pkg;
    localparam int COORD_W = 24;
    localparam int SUM_W   = 40;
    localparam int LEN_W   = 48;
    localparam int CNT_W   = 17;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int RAD_W   = 2 * DIFF_W + 1;   // 51-bit radicand
    localparam int ROOT_W  = (RAD_W + 1) / 2;  // 26-bit root
    localparam int RSTEPS  = ROOT_W;
    localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(65536);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] centroid_x;
        logic signed [COORD_W-1:0] centroid_y;
        logic [LEN_W-1:0]          path_length;
        logic [CNT_W-1:0]          point_count;
        logic                      overflow;
    } out_word_t;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        logic                      accept;   // point is taken into the set
        logic                      seg;      // a segment length is due
        logic                      last;     // emit the result afterwards
        logic [RAD_W-1:0]          radicand; // dx^2 + dy^2
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROOT, ST_DIV, ST_OUT
    } back_state_t;
endpackage

// File: rtl/plc_front.sv
// Front part: accepts points, forms dx^2+dy^2 and pushes a job.
// Depends on plc_pkg.
`timescale 1ns / 1ps
module plc_front
    import plc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job_data,
    output logic signed [COORD_W-1:0] pt_x,
    output logic signed [COORD_W-1:0] pt_y
);
    // Stage 1 registers: differences. The squares are then summed combinationally.
    logic                     s1_valid_reg, s1_acc_reg, s1_seg_reg, s1_last_reg;
    logic [DIFF_W-1:0]        s1_mx_reg, s1_my_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [DIFF_W-1:0] dx, dy;
    logic                     take, acc;
    logic [2*DIFF_W-1:0]      sq_x, sq_y;

    // One point in flight at a time through the front.
    assign s_ready = !s1_valid_reg;
    assign take    = s_valid && s_ready;
    assign acc     = cnt_reg != MAX_POINTS;
    assign dx = DIFF_W'(s_data.point_x) - DIFF_W'(prev_x_reg);
    assign dy = DIFF_W'(s_data.point_y) - DIFF_W'(prev_y_reg);

    // Point counter and previous point, kept for the segment difference.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end else begin
            if (take) begin
                s1_valid_reg <= 1'b1;
                if (s_data.last_point) cnt_reg <= '0;
                else if (acc) cnt_reg <= cnt_reg + 1'b1;
                if (acc) begin
                    prev_x_reg <= s_data.point_x;
                    prev_y_reg <= s_data.point_y;
                end
            end else if (job_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the difference stage.
    always_ff @(posedge aclk) begin
        if (take) begin
            s1_acc_reg  <= acc;
            s1_seg_reg  <= acc && (cnt_reg != '0);
            s1_last_reg <= s_data.last_point;
            s1_mx_reg   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            s1_my_reg   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            s1_x_reg    <= s_data.point_x;
            s1_y_reg    <= s_data.point_y;
        end
    end

    // Squares are 25x25 multiplies; result goes straight into the queue.
    assign sq_x = s1_mx_reg * s1_mx_reg;
    assign sq_y = s1_my_reg * s1_my_reg;
    assign job_valid         = s1_valid_reg;
    assign job_data.accept   = s1_acc_reg;
    assign job_data.seg      = s1_seg_reg;
    assign job_data.last     = s1_last_reg;
    assign job_data.radicand = {1'b0, sq_x} + {1'b0, sq_y};
    assign pt_x = s1_x_reg;
    assign pt_y = s1_y_reg;
endmodule

// File: rtl/plc_queue.sv
// Two-entry job queue between front and back parts.
// Depends on plc_pkg.
`timescale 1ns / 1ps
module plc_queue
    import plc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y
);
    localparam int EW = $bits(job_t) + 2 * COORD_W;
    logic [EW-1:0] mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign {out_job, out_x, out_y} = mem_reg[rp_reg];

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= {in_job, in_x, in_y};
    end
endmodule

// File: rtl/plc_back.sv
// Back part: iterative square root, accumulation and serial division.
// Depends on plc_pkg.
`timescale 1ns / 1ps
module plc_back
    import plc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job_data,
    input  logic signed [COORD_W-1:0] pt_x,
    input  logic signed [COORD_W-1:0] pt_y,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    localparam int DQ_W = SUM_W;
    localparam int SC_W = $clog2(DQ_W + 1);

    back_state_t state_reg, state_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              drop_reg, last_reg;
    logic [RAD_W+1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SC_W-1:0]   step_reg;
    // Serial dividers for both axes, one quotient bit a cycle.
    logic [DQ_W-1:0]   qx_reg, qy_reg;
    logic [CNT_W:0]    rx_reg, ry_reg;
    logic              nx_reg, ny_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic [ROOT_W+1:0] rem_sh, trial;
    logic [CNT_W:0]    rx_sh, ry_sh;
    logic [LEN_W:0]    len_sum;
    logic [SUM_W-1:0]  ax, ay;
    logic              out_fire;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W+1:RAD_W]};
    assign trial  = {root_reg, 2'b01};
    assign rx_sh  = {rx_reg[CNT_W-1:0], qx_reg[DQ_W-1]};
    assign ry_sh  = {ry_reg[CNT_W-1:0], qy_reg[DQ_W-1]};
    // Length plus the finished root, including its last bit.
    assign len_sum = {1'b0, len_reg}
                   + (LEN_W + 1)'({root_reg[ROOT_W-2:0], (rem_sh >= trial)});
    assign ax = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign ay = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign out_fire = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);

    assign job_ready = state_reg == ST_IDLE;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = job_data.seg ? ST_ROOT
                                             : (job_data.last ? ST_DIV : ST_IDLE);
            ST_ROOT: if (step_reg == SC_W'(RSTEPS - 1))
                         state_next = last_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (step_reg == SC_W'(DQ_W)) state_next = ST_OUT;
            ST_OUT:  if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Running state, root iterations and division.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0; sum_y_reg <= '0; len_reg <= '0;
            cnt_reg <= '0; drop_reg <= 1'b0; out_valid_reg <= 1'b0;
            last_reg <= 1'b0; step_reg <= '0;
        end else begin
            if (out_fire) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (job_valid) begin
                    last_reg <= job_data.last;
                    step_reg <= '0;
                    if (job_data.accept) begin
                        sum_x_reg <= sum_x_reg + SUM_W'(pt_x);
                        sum_y_reg <= sum_y_reg + SUM_W'(pt_y);
                        cnt_reg   <= cnt_reg + 1'b1;
                    end else begin
                        drop_reg <= 1'b1;
                    end
                    rad_reg  <= {1'b0, job_data.radicand, 1'b0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                ST_ROOT: begin
                    rad_reg <= rad_reg << 2;
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    if (step_reg == SC_W'(RSTEPS - 1)) step_reg <= '0;
                    else step_reg <= step_reg + 1'b1;
                end
                ST_DIV: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == '0) begin
                        qx_reg <= ax; qy_reg <= ay;
                        nx_reg <= sum_x_reg[SUM_W-1];
                        ny_reg <= sum_y_reg[SUM_W-1];
                        rx_reg <= '0; ry_reg <= '0;
                    end else begin
                        if (rx_sh >= {1'b0, cnt_reg}) begin
                            rx_reg <= rx_sh - {1'b0, cnt_reg};
                            qx_reg <= {qx_reg[DQ_W-2:0], 1'b1};
                        end else begin
                            rx_reg <= rx_sh;
                            qx_reg <= {qx_reg[DQ_W-2:0], 1'b0};
                        end
                        if (ry_sh >= {1'b0, cnt_reg}) begin
                            ry_reg <= ry_sh - {1'b0, cnt_reg};
                            qy_reg <= {qy_reg[DQ_W-2:0], 1'b1};
                        end else begin
                            ry_reg <= ry_sh;
                            qy_reg <= {qy_reg[DQ_W-2:0], 1'b0};
                        end
                    end
                end
                ST_OUT: if (out_fire) begin
                    out_reg.centroid_x  <= nx_reg ? COORD_W'(-qx_reg) : COORD_W'(qx_reg);
                    out_reg.centroid_y  <= ny_reg ? COORD_W'(-qy_reg) : COORD_W'(qy_reg);
                    out_reg.path_length <= len_reg;
                    out_reg.point_count <= cnt_reg;
                    out_reg.overflow    <= drop_reg;
                    sum_x_reg <= '0; sum_y_reg <= '0; len_reg <= '0;
                    cnt_reg <= '0; drop_reg <= 1'b0;
                end
                default: ;
            endcase
            // Segment length is added once the last root bit is in.
            if (state_reg == ST_ROOT && step_reg == SC_W'(RSTEPS - 1)) begin
                if (len_sum > (LEN_W + 1)'(LEN_MAX)) begin
                    len_reg  <= LEN_MAX;
                    drop_reg <= 1'b1;
                end else begin
                    len_reg <= len_sum[LEN_W-1:0];
                end
            end
        end
    end
endmodule

// File: rtl/polyline_length_and_centroid_top.sv
// Polyline length and centroid: top level joining front, queue and back.
// Path: front register, job queue, back part; each segment runs the serial
// root, and a last point adds the serial division and a registered output.
// The back part takes a new job only when idle; the queue buffers up to two.
// Reset: synchronous active-low aresetn clears the running sums, counts, overflow flag and valid bits.
`timescale 1ns / 1ps
module polyline_length_and_centroid_top
    import plc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    logic fj_valid, fj_ready, qj_valid, qj_ready;
    job_t fj_data, qj_data;
    logic signed [COORD_W-1:0] fx, fy, qx, qy;

    // Front part.
    plc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data),
        .pt_x(fx), .pt_y(fy)
    );

    // Decoupling queue.
    plc_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj_data),
        .in_x(fx), .in_y(fy),
        .out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj_data),
        .out_x(qx), .out_y(qy)
    );

    // Back part.
    plc_back u_back (
        .aclk, .aresetn,
        .job_valid(qj_valid), .job_ready(qj_ready), .job_data(qj_data),
        .pt_x(qx), .pt_y(qy), .m_valid, .m_ready, .m_data
    );
endmodule

// File: rtl/plc_checker.sv
// Port-level checker for the polyline block, bound to the top level.
// Depends on plc_pkg.
`timescale 1ns / 1ps
module plc_port_checker
    import plc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);
    // A result word holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");
    // Every result reports at least one point.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.point_count != '0)
        else $error("result with zero points");
    // Count never exceeds capacity.
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.point_count <= MAX_POINTS)
        else $error("count above capacity");
    // No output right after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind polyline_length_and_centroid_top plc_port_checker u_plc_checker (.*);
